### rtl/i2crf_pkg.sv
// Shared constants, codes and helper functions for the I2C target register file.
`timescale 1ns / 1ps

package i2crf_pkg;

    localparam int unsigned REG_SPACE_DFLT = 128;
    localparam int unsigned PTR_W          = 8;
    localparam int unsigned EXT_W          = PTR_W + 1;
    localparam int unsigned OP_W           = 3;
    localparam int unsigned LEN_W          = 3;
    localparam int unsigned DATA_W         = 32;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned LANE_W         = 2;

    localparam logic [OP_W-1:0] OP_BUS_WR   = 3'd0;
    localparam logic [OP_W-1:0] OP_BUS_RD   = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP     = 3'd2;
    localparam logic [OP_W-1:0] OP_LOC_RD   = 3'd3;
    localparam logic [OP_W-1:0] OP_LOC_WR   = 3'd4;
    localparam logic [OP_W-1:0] OP_TAKE_CMD = 3'd5;
    localparam logic [OP_W-1:0] OP_TAKE_CFG = 3'd6;

    localparam logic [LEN_W-1:0] LEN_MAX = 3'd4;

    localparam logic [EXT_W-1:0] CMD_LO = 9'h010;
    localparam logic [EXT_W-1:0] CMD_HI = 9'h01F;
    localparam logic [EXT_W-1:0] CFG_LO = 9'h040;
    localparam logic [EXT_W-1:0] CFG_HI = 9'h05F;

    // Control into the shared address unit
    typedef struct packed {
        logic             load;
        logic             step;
        logic [PTR_W-1:0] base;
    } walk_ctl_t;

    // Status out of the shared address unit
    typedef struct packed {
        logic [EXT_W-1:0] addr;
        logic             in_range;
    } walk_sts_t;

    function automatic logic in_cmd_region(input logic [EXT_W-1:0] a);
        return (a >= CMD_LO) && (a <= CMD_HI);
    endfunction

    function automatic logic in_cfg_region(input logic [EXT_W-1:0] a);
        return (a >= CFG_LO) && (a <= CFG_HI);
    endfunction

endpackage

### rtl/i2crf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module i2crf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/i2crf_walk.sv
// Shared address unit: step counter plus base adder and register-space range check.
`timescale 1ns / 1ps

module i2crf_walk
    import i2crf_pkg::*;
#(
    parameter int unsigned REG_SPACE = REG_SPACE_DFLT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  walk_ctl_t                      ctl,
    output logic [$clog2(REG_SPACE+1)-1:0] cnt,
    output walk_sts_t                      sts
);

    localparam int unsigned CW = $clog2(REG_SPACE + 1);

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [PTR_W-1:0] base_reg, base_next;
    logic [EXT_W-1:0] sum;

    always_comb
    begin
        cnt_next  = cnt_reg;
        base_next = base_reg;
        if (ctl.load)
        begin
            cnt_next  = '0;
            base_next = ctl.base;
        end
        else if (ctl.step)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            base_reg <= base_next;
        end
    end

    // base is zero on full walks, so the sum never exceeds the 9-bit range
    assign sum          = {1'b0, base_reg} + EXT_W'(cnt_reg);
    assign sts.addr     = sum;
    assign sts.in_range = (sum < EXT_W'(REG_SPACE));
    assign cnt          = cnt_reg;

endmodule

### rtl/i2c_target_register_file.sv
// Bus write, stop with nothing staged and flag take go from idle straight to the finish step.
// Bus read: snapshot read and data steps, after a snapshot walk on the first read of a transaction.
// Stop with staged bytes: commit walk over the space. Local access: a byte walk of the length, then finish.
// One word in work at a time; input stalls until the result sits in the output register.
// Walks use the shared address unit to step through the image, snapshot and staging RAMs.
// Reset (rst_n low, async) clears pointer, flags, dirty marks and image valid bits.
`timescale 1ns / 1ps

module i2c_target_register_file
    import i2crf_pkg::*;
#(
    parameter int unsigned REG_SPACE = REG_SPACE_DFLT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   op,
    input  logic [PTR_W-1:0]  bus_byte,
    input  logic [PTR_W-1:0]  local_addr,
    input  logic [LEN_W-1:0]  local_len,
    input  logic [DATA_W-1:0] local_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] read_data,
    output logic              flag_taken
);

    localparam int unsigned AW = $clog2(REG_SPACE);
    localparam int unsigned CW = $clog2(REG_SPACE + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SNAP   = 3'd1;
    localparam logic [2:0] ST_SREAD  = 3'd2;
    localparam logic [2:0] ST_SRDATA = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;
    localparam logic [2:0] ST_LREAD  = 3'd5;
    localparam logic [2:0] ST_LWRITE = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic                 loaded_reg, loaded_next;
    logic                 snap_taken_reg, snap_taken_next;
    logic                 any_staged_reg, any_staged_next;
    logic                 cmd_flag_reg, cmd_flag_next;
    logic                 cfg_flag_reg, cfg_flag_next;
    logic [REG_SPACE-1:0] mark_reg, mark_next;
    logic [REG_SPACE-1:0] valid_reg, valid_next;
    logic [LEN_W-1:0]     count_reg, count_next;
    logic [DATA_W-1:0]    value_reg, value_next;
    logic [DATA_W-1:0]    res_data_reg, res_data_next;
    logic                 res_flag_reg, res_flag_next;
    logic [AW-1:0]        prev_idx_reg, prev_idx_next;
    logic                 prev_ok_reg, prev_ok_next;
    logic [LANE_W-1:0]    prev_lane_reg, prev_lane_next;
    logic                 pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    read_data_reg, read_data_next;
    logic                 flag_taken_reg, flag_taken_next;

    walk_ctl_t            walk_ctl;
    walk_sts_t            walk_sts;
    logic [CW-1:0]        walk_cnt;
    logic [AW-1:0]        idx;
    logic                 ptr_in_space;
    logic [LEN_W-1:0]     len_clamped;
    logic                 more_bytes;

    logic                 img_we, img_re;
    logic [AW-1:0]        img_waddr, img_raddr;
    logic [BYTE_W-1:0]    img_wdata, img_q;
    logic                 snap_we, snap_re;
    logic [AW-1:0]        snap_waddr, snap_raddr;
    logic [BYTE_W-1:0]    snap_wdata, snap_q;
    logic                 stg_we, stg_re;
    logic [AW-1:0]        stg_waddr, stg_raddr;
    logic [BYTE_W-1:0]    stg_wdata, stg_q;

    i2crf_walk #(.REG_SPACE(REG_SPACE)) u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (walk_ctl),
        .cnt   (walk_cnt),
        .sts   (walk_sts)
    );

    i2crf_ram #(.WIDTH(BYTE_W), .DEPTH(REG_SPACE)) u_image (
        .clk   (clk),
        .we    (img_we),
        .waddr (img_waddr),
        .wdata (img_wdata),
        .re    (img_re),
        .raddr (img_raddr),
        .rdata (img_q)
    );

    i2crf_ram #(.WIDTH(BYTE_W), .DEPTH(REG_SPACE)) u_snapshot (
        .clk   (clk),
        .we    (snap_we),
        .waddr (snap_waddr),
        .wdata (snap_wdata),
        .re    (snap_re),
        .raddr (snap_raddr),
        .rdata (snap_q)
    );

    i2crf_ram #(.WIDTH(BYTE_W), .DEPTH(REG_SPACE)) u_staged (
        .clk   (clk),
        .we    (stg_we),
        .waddr (stg_waddr),
        .wdata (stg_wdata),
        .re    (stg_re),
        .raddr (stg_raddr),
        .rdata (stg_q)
    );

    assign idx          = walk_sts.addr[AW-1:0];
    assign ptr_in_space = ({1'b0, ptr_reg} < EXT_W'(REG_SPACE));
    assign len_clamped  = (local_len > LEN_MAX) ? LEN_MAX : local_len;
    assign more_bytes   = (walk_cnt < CW'(count_reg));

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        loaded_next     = loaded_reg;
        snap_taken_next = snap_taken_reg;
        any_staged_next = any_staged_reg;
        cmd_flag_next   = cmd_flag_reg;
        cfg_flag_next   = cfg_flag_reg;
        mark_next       = mark_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        value_next      = value_reg;
        res_data_next   = res_data_reg;
        res_flag_next   = res_flag_reg;
        prev_idx_next   = prev_idx_reg;
        prev_ok_next    = prev_ok_reg;
        prev_lane_next  = prev_lane_reg;
        pend_next       = 1'b0;
        out_valid_next  = out_valid_reg;
        read_data_next  = read_data_reg;
        flag_taken_next = flag_taken_reg;

        walk_ctl.load = 1'b0;
        walk_ctl.step = 1'b0;
        walk_ctl.base = '0;

        img_we     = 1'b0;
        img_waddr  = idx;
        img_wdata  = value_reg[{walk_cnt[LANE_W-1:0], 3'b000} +: BYTE_W];
        img_re     = 1'b0;
        img_raddr  = idx;
        snap_we    = 1'b0;
        snap_waddr = prev_idx_reg;
        snap_wdata = prev_ok_reg ? img_q : '0;
        snap_re    = 1'b0;
        snap_raddr = ptr_reg[AW-1:0];
        stg_we     = 1'b0;
        stg_waddr  = ptr_reg[AW-1:0];
        stg_wdata  = bus_byte;
        stg_re     = 1'b0;
        stg_raddr  = idx;

        // drop the delivered word
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_data_next = '0;
                    res_flag_next = 1'b0;
                    count_next    = len_clamped;
                    value_next    = local_value;
                    state_next    = ST_FINISH;
                    case (op)
                        OP_BUS_WR:
                        begin
                            if (!loaded_reg)
                            begin
                                ptr_next    = bus_byte;
                                loaded_next = 1'b1;
                            end
                            else
                            begin
                                if (ptr_in_space && (in_cmd_region({1'b0, ptr_reg})
                                    || in_cfg_region({1'b0, ptr_reg})))
                                begin
                                    stg_we                      = 1'b1;
                                    mark_next[ptr_reg[AW-1:0]]  = 1'b1;
                                    any_staged_next             = 1'b1;
                                end
                                ptr_next = ptr_reg + PTR_W'(1);
                            end
                        end
                        OP_BUS_RD:
                        begin
                            if (snap_taken_reg)
                            begin
                                state_next = ST_SREAD;
                            end
                            else
                            begin
                                walk_ctl.load = 1'b1;
                                state_next    = ST_SNAP;
                            end
                        end
                        OP_STOP:
                        begin
                            if (any_staged_reg)
                            begin
                                walk_ctl.load = 1'b1;
                                state_next    = ST_COMMIT;
                            end
                            else
                            begin
                                loaded_next     = 1'b0;
                                snap_taken_next = 1'b0;
                            end
                        end
                        OP_LOC_RD:
                        begin
                            walk_ctl.load = 1'b1;
                            walk_ctl.base = local_addr;
                            state_next    = ST_LREAD;
                        end
                        OP_LOC_WR:
                        begin
                            walk_ctl.load = 1'b1;
                            walk_ctl.base = local_addr;
                            state_next    = ST_LWRITE;
                        end
                        OP_TAKE_CMD:
                        begin
                            res_flag_next = cmd_flag_reg;
                            cmd_flag_next = 1'b0;
                        end
                        OP_TAKE_CFG:
                        begin
                            res_flag_next = cfg_flag_reg;
                            cfg_flag_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SNAP:
            begin
                // read entry n while writing entry n-1 into the snapshot
                if (pend_reg)
                begin
                    snap_we = 1'b1;
                end
                if (walk_sts.in_range)
                begin
                    img_re        = 1'b1;
                    prev_idx_next = idx;
                    prev_ok_next  = valid_reg[idx];
                    pend_next     = 1'b1;
                    walk_ctl.step = 1'b1;
                end
                else
                begin
                    snap_taken_next = 1'b1;
                    state_next      = ST_SREAD;
                end
            end

            ST_SREAD:
            begin
                snap_re      = ptr_in_space;
                prev_ok_next = ptr_in_space;
                state_next   = ST_SRDATA;
            end

            ST_SRDATA:
            begin
                res_data_next = prev_ok_reg ? DATA_W'(snap_q) : '0;
                ptr_next      = ptr_reg + PTR_W'(1);
                state_next    = ST_FINISH;
            end

            ST_COMMIT:
            begin
                if (pend_reg && prev_ok_reg)
                begin
                    img_we                   = 1'b1;
                    img_waddr                = prev_idx_reg;
                    img_wdata                = stg_q;
                    valid_next[prev_idx_reg] = 1'b1;
                    mark_next[prev_idx_reg]  = 1'b0;
                    if (in_cmd_region(EXT_W'(prev_idx_reg)))
                    begin
                        cmd_flag_next = 1'b1;
                    end
                    else if (in_cfg_region(EXT_W'(prev_idx_reg)))
                    begin
                        cfg_flag_next = 1'b1;
                    end
                end
                if (walk_sts.in_range)
                begin
                    stg_re        = mark_reg[idx];
                    prev_idx_next = idx;
                    prev_ok_next  = mark_reg[idx];
                    pend_next     = 1'b1;
                    walk_ctl.step = 1'b1;
                end
                else
                begin
                    any_staged_next = 1'b0;
                    loaded_next     = 1'b0;
                    snap_taken_next = 1'b0;
                    state_next      = ST_FINISH;
                end
            end

            ST_LREAD:
            begin
                if (pend_reg && prev_ok_reg)
                begin
                    res_data_next[{prev_lane_reg, 3'b000} +: BYTE_W] = img_q;
                end
                if (more_bytes)
                begin
                    img_re         = walk_sts.in_range;
                    prev_ok_next   = walk_sts.in_range && valid_reg[idx];
                    prev_lane_next = walk_cnt[LANE_W-1:0];
                    pend_next      = 1'b1;
                    walk_ctl.step  = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_LWRITE:
            begin
                if (more_bytes)
                begin
                    if (walk_sts.in_range)
                    begin
                        img_we          = 1'b1;
                        valid_next[idx] = 1'b1;
                    end
                    walk_ctl.step = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    read_data_next  = res_data_reg;
                    flag_taken_next = res_flag_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ptr_reg        <= '0;
            loaded_reg     <= 1'b0;
            snap_taken_reg <= 1'b0;
            any_staged_reg <= 1'b0;
            cmd_flag_reg   <= 1'b0;
            cfg_flag_reg   <= 1'b0;
            mark_reg       <= '0;
            valid_reg      <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            loaded_reg     <= loaded_next;
            snap_taken_reg <= snap_taken_next;
            any_staged_reg <= any_staged_next;
            cmd_flag_reg   <= cmd_flag_next;
            cfg_flag_reg   <= cfg_flag_next;
            mark_reg       <= mark_next;
            valid_reg      <= valid_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg      <= count_next;
        value_reg      <= value_next;
        res_data_reg   <= res_data_next;
        res_flag_reg   <= res_flag_next;
        prev_idx_reg   <= prev_idx_next;
        prev_ok_reg    <= prev_ok_next;
        prev_lane_reg  <= prev_lane_next;
        read_data_reg  <= read_data_next;
        flag_taken_reg <= flag_taken_next;
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign flag_taken = flag_taken_reg;

endmodule

### rtl/i2crf_checker.sv
// Port-level checker for the I2C target register file, bound to the top level.
`timescale 1ns / 1ps

module i2crf_checker
    import i2crf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [DATA_W-1:0] read_data,
    input logic              flag_taken
);

    logic       in_acc, out_acc;
    logic [1:0] pend_reg, pend_next;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // words accepted but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc && !out_acc)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(flag_taken))
        else $error("result word changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("input not stalled while a word is in work");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result word without an accepted input word");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two words outstanding");

endmodule

bind i2c_target_register_file i2crf_checker u_i2crf_checker (.*);

### tb/sv/i2c_target_register_file_tb.sv
// Self-checking testbench for the I2C target register file: queued words, prediction, checks.
`timescale 1ns / 1ps

module i2c_target_register_file_tb;

    import i2crf_pkg::*;

    localparam int unsigned    REG_SPACE = REG_SPACE_DFLT;
    localparam logic [OP_W-1:0] OP_NONE  = 3'd7;
    localparam int unsigned    WORDS_PER_PHASE = 160;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PTR_W-1:0]  bus_byte;
        logic [PTR_W-1:0]  local_addr;
        logic [LEN_W-1:0]  local_len;
        logic [DATA_W-1:0] local_value;
    } word_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              flag_taken;
    } reply_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DATA_W-1:0] read_data;
    logic              flag_taken;
    word_t             cur_word  = '0;

    logic [OP_W-1:0]   op;
    logic [PTR_W-1:0]  bus_byte;
    logic [PTR_W-1:0]  local_addr;
    logic [LEN_W-1:0]  local_len;
    logic [DATA_W-1:0] local_value;

    assign op          = cur_word.op;
    assign bus_byte    = cur_word.bus_byte;
    assign local_addr  = cur_word.local_addr;
    assign local_len   = cur_word.local_len;
    assign local_value = cur_word.local_value;

    // Predicted state of the register file
    logic [7:0]       image      [REG_SPACE];
    logic [7:0]       snapshot   [REG_SPACE];
    logic [7:0]       staged     [REG_SPACE];
    logic             dirty      [REG_SPACE];
    logic [PTR_W-1:0] reg_ptr;
    logic             ptr_loaded;
    logic             snap_valid;
    logic             any_dirty;
    logic             cmd_pending;
    logic             cfg_pending;

    word_t  queued_words[$];
    reply_t owed_replies[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned words_accepted = 0;
    int unsigned replies_seen   = 0;
    int unsigned commits_seen   = 0;
    int unsigned snapshots_seen = 0;

    i2c_target_register_file #(
        .REG_SPACE (REG_SPACE)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .bus_byte    (bus_byte),
        .local_addr  (local_addr),
        .local_len   (local_len),
        .local_value (local_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .flag_taken  (flag_taken)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic is_cmd_addr(input int unsigned a);
        return (a >= CMD_LO) && (a <= CMD_HI);
    endfunction

    function automatic logic is_cfg_addr(input int unsigned a);
        return (a >= CFG_LO) && (a <= CFG_HI);
    endfunction

    task automatic predict_reply(input word_t w, output reply_t r);
        int unsigned cnt;
        int unsigned a;
        r   = '0;
        cnt = 32'((w.local_len > LEN_MAX) ? LEN_MAX : w.local_len);
        case (w.op)
            OP_BUS_WR:
            begin
                if (!ptr_loaded)
                begin
                    reg_ptr    = w.bus_byte;
                    ptr_loaded = 1'b1;
                end
                else
                begin
                    if (reg_ptr < REG_SPACE
                        && (is_cmd_addr(32'(reg_ptr)) || is_cfg_addr(32'(reg_ptr))))
                    begin
                        staged[reg_ptr] = w.bus_byte;
                        dirty[reg_ptr]  = 1'b1;
                        any_dirty       = 1'b1;
                    end
                    reg_ptr = reg_ptr + PTR_W'(1);
                end
            end
            OP_BUS_RD:
            begin
                if (!snap_valid)
                begin
                    snapshot   = image;
                    snap_valid = 1'b1;
                    snapshots_seen++;
                end
                if (reg_ptr < REG_SPACE)
                    r.read_data = DATA_W'(snapshot[reg_ptr]);
                reg_ptr = reg_ptr + PTR_W'(1);
            end
            OP_STOP:
            begin
                if (any_dirty)
                begin
                    commits_seen++;
                    for (int i = 0; i < REG_SPACE; i++)
                    begin
                        if (dirty[i])
                        begin
                            image[i] = staged[i];
                            if (is_cmd_addr(i))
                                cmd_pending = 1'b1;
                            else if (is_cfg_addr(i))
                                cfg_pending = 1'b1;
                            dirty[i] = 1'b0;
                        end
                    end
                    any_dirty = 1'b0;
                end
                ptr_loaded = 1'b0;
                snap_valid = 1'b0;
            end
            OP_LOC_RD:
                for (int i = 0; i < cnt; i++)
                begin
                    a = w.local_addr + i;
                    if (a < REG_SPACE)
                        r.read_data |= DATA_W'(image[a]) << (8 * i);
                end
            OP_LOC_WR:
                for (int i = 0; i < cnt; i++)
                begin
                    a = w.local_addr + i;
                    if (a < REG_SPACE)
                        image[a] = w.local_value[8*i +: 8];
                end
            OP_TAKE_CMD:
            begin
                r.flag_taken = cmd_pending;
                cmd_pending  = 1'b0;
            end
            OP_TAKE_CFG:
            begin
                r.flag_taken = cfg_pending;
                cfg_pending  = 1'b0;
            end
            default:
                ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("MISMATCH %s at %0t ns: got %h, want %h", what, $time, got, want);
        error_count++;
    endtask

    function automatic void push_word(input logic [OP_W-1:0] o, input logic [PTR_W-1:0] b,
                                      input logic [PTR_W-1:0] a, input logic [LEN_W-1:0] l,
                                      input logic [DATA_W-1:0] v);
        word_t w;
        w.op          = o;
        w.bus_byte    = b;
        w.local_addr  = a;
        w.local_len   = l;
        w.local_value = v;
        queued_words.push_back(w);
    endfunction

    // Bias addresses toward the staging regions and the end of the space
    function automatic logic [PTR_W-1:0] pick_addr();
        case ($urandom_range(0, 4))
            0:       return PTR_W'($urandom_range(8'h0C, 8'h21));
            1:       return PTR_W'($urandom_range(8'h3C, 8'h61));
            2:       return PTR_W'($urandom_range(REG_SPACE - 6, REG_SPACE + 2));
            3:       return PTR_W'($urandom_range(8'hF8, 8'hFF));
            default: return PTR_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 3'd1;
        else if (r < 6)
            return 3'd2;
        else if (r < 8)
            return LEN_MAX;
        return LEN_W'($urandom_range(0, 7));
    endfunction

    task automatic add_random_words(input int unsigned goal);
        int unsigned start;
        int unsigned kind;
        int unsigned n;
        start = queued_words.size();
        while (queued_words.size() - start < goal)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                // write transaction, sometimes followed by reads before stop
                push_word(OP_BUS_WR, pick_addr(), PTR_W'($urandom), LEN_W'($urandom),
                          $urandom);
                n = $urandom_range(1, 6);
                repeat (n)
                    push_word(OP_BUS_WR, PTR_W'($urandom), PTR_W'($urandom),
                              LEN_W'($urandom), $urandom);
                if ($urandom_range(0, 1))
                    repeat ($urandom_range(1, 3))
                        push_word(OP_BUS_RD, PTR_W'($urandom), PTR_W'($urandom),
                                  LEN_W'($urandom), $urandom);
                push_word(OP_STOP, PTR_W'($urandom), PTR_W'($urandom), LEN_W'($urandom),
                          $urandom);
            end
            else if (kind < 60)
            begin
                if ($urandom_range(0, 9) < 7)
                    push_word(OP_BUS_WR, pick_addr(), PTR_W'($urandom), LEN_W'($urandom),
                              $urandom);
                repeat ($urandom_range(1, 5))
                    push_word(OP_BUS_RD, PTR_W'($urandom), PTR_W'($urandom),
                              LEN_W'($urandom), $urandom);
                push_word(OP_STOP, PTR_W'($urandom), PTR_W'($urandom), LEN_W'($urandom),
                          $urandom);
            end
            else if (kind < 85)
            begin
                case ($urandom_range(0, 5))
                    0, 1:
                        push_word(OP_LOC_RD, PTR_W'($urandom), pick_addr(), pick_len(),
                                  $urandom);
                    2, 3:
                        push_word(OP_LOC_WR, PTR_W'($urandom), pick_addr(), pick_len(),
                                  $urandom);
                    4:
                        push_word(OP_TAKE_CMD, PTR_W'($urandom), PTR_W'($urandom),
                                  LEN_W'($urandom), $urandom);
                    default:
                        push_word(OP_TAKE_CFG, PTR_W'($urandom), PTR_W'($urandom),
                                  LEN_W'($urandom), $urandom);
                endcase
            end
            else
                push_word(OP_W'($urandom_range(0, 7)), PTR_W'($urandom), PTR_W'($urandom),
                          LEN_W'($urandom), $urandom);
        end
    endtask

    // Driver: hold the word while stalled, advance on accept
    always @(posedge clk or negedge rst_n)
    begin : drive_words
        reply_t rep;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cur_word <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_reply(cur_word, rep);
                owed_replies.push_back(rep);
                words_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (queued_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_word <= queued_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result against the oldest owed reply
    always @(posedge clk or negedge rst_n)
    begin : check_replies
        reply_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_replies.size() == 0)
                    report_mismatch("unexpected result", read_data, '0);
                else
                begin
                    want = owed_replies.pop_front();
                    if (read_data !== want.read_data)
                        report_mismatch("read_data", read_data, want.read_data);
                    if (flag_taken !== want.flag_taken)
                        report_mismatch("flag_taken", DATA_W'(flag_taken),
                                        DATA_W'(want.flag_taken));
                    replies_seen++;
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin
        #10_000_000;
        $display("Timeout at %0t ns", $time);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < REG_SPACE; i++)
        begin
            image[i]    = '0;
            snapshot[i] = '0;
            staged[i]   = '0;
            dirty[i]    = 1'b0;
        end
        reg_ptr     = '0;
        ptr_loaded  = 1'b0;
        snap_valid  = 1'b0;
        any_dirty   = 1'b0;
        cmd_pending = 1'b0;
        cfg_pending = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 68;
                end
                1:
                begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 13;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            if (phase == 0)
            begin
                // read straight out of reset, then stop with nothing staged
                push_word(OP_BUS_RD, 8'h00, 8'h00, 3'd1, '0);
                push_word(OP_STOP, 8'h00, 8'h00, 3'd1, '0);
                push_word(OP_TAKE_CMD, 8'hFF, 8'hFF, 3'd7, '1);
                push_word(OP_TAKE_CFG, 8'h00, 8'h00, 3'd0, '0);
                push_word(OP_LOC_WR, 8'h00, 8'h10, LEN_MAX, 32'hFFFF_FFFF);
                push_word(OP_LOC_RD, 8'h00, 8'h10, LEN_MAX, '0);
                // local bytes running off the end of the space
                push_word(OP_LOC_WR, 8'hFF, PTR_W'(REG_SPACE - 2), LEN_MAX, 32'hA5C3_3C5A);
                push_word(OP_LOC_RD, 8'h00, PTR_W'(REG_SPACE - 2), LEN_MAX, '0);
                push_word(OP_LOC_RD, 8'h00, 8'hFF, LEN_MAX, '0);
                // odd lengths: three, oversized, zero
                push_word(OP_LOC_WR, 8'h00, 8'h00, 3'd3, 32'h1234_5678);
                push_word(OP_LOC_RD, 8'h00, 8'h00, 3'd7, '0);
                push_word(OP_LOC_RD, 8'h00, 8'h00, 3'd0, '0);
                // staged writes into the command region, then take the flag twice
                push_word(OP_BUS_WR, 8'h1E, 8'h00, 3'd1, '0);
                push_word(OP_BUS_WR, 8'hAA, 8'h00, 3'd1, '0);
                push_word(OP_BUS_WR, 8'h55, 8'h00, 3'd1, '0);
                push_word(OP_STOP, 8'h00, 8'h00, 3'd1, '0);
                push_word(OP_TAKE_CMD, 8'h00, 8'h00, 3'd1, '0);
                push_word(OP_TAKE_CMD, 8'h00, 8'h00, 3'd1, '0);
                // config region end, next byte dropped
                push_word(OP_BUS_WR, 8'h5F, 8'h00, 3'd1, '0);
                push_word(OP_BUS_WR, 8'h00, 8'h00, 3'd1, '0);
                push_word(OP_BUS_WR, 8'hFF, 8'h00, 3'd1, '0);
                push_word(OP_STOP, 8'h00, 8'h00, 3'd1, '0);
                push_word(OP_TAKE_CFG, 8'h00, 8'h00, 3'd1, '0);
                // pointer wrap at 0xFF, then a read past the space
                push_word(OP_BUS_WR, 8'hFF, 8'h00, 3'd1, '0);
                push_word(OP_BUS_WR, 8'h12, 8'h00, 3'd1, '0);
                push_word(OP_BUS_RD, 8'h00, 8'h00, 3'd1, '0);
                push_word(OP_STOP, 8'h00, 8'h00, 3'd1, '0);
                push_word(OP_BUS_WR, 8'h90, 8'h00, 3'd1, '0);
                push_word(OP_BUS_RD, 8'h00, 8'h00, 3'd1, '0);
                push_word(OP_STOP, 8'h00, 8'h00, 3'd1, '0);
                // local write must not disturb the snapshot of an open transaction
                push_word(OP_BUS_WR, 8'h10, 8'h00, 3'd1, '0);
                push_word(OP_BUS_RD, 8'h00, 8'h00, 3'd1, '0);
                push_word(OP_LOC_WR, 8'h00, 8'h11, 3'd1, 32'h0000_0077);
                push_word(OP_BUS_RD, 8'h00, 8'h00, 3'd1, '0);
                push_word(OP_STOP, 8'h00, 8'h00, 3'd1, '0);
                push_word(OP_NONE, 8'hFF, 8'hFF, 3'd7, '1);
            end
            add_random_words(WORDS_PER_PHASE);

            // drain: no new words until every owed reply has come back
            while (queued_words.size() != 0 || in_valid || owed_replies.size() != 0)
                @(posedge clk);
        end

        repeat (REG_SPACE + 8) @(posedge clk);
        if (owed_replies.size() != 0)
            report_mismatch("replies never returned", owed_replies.size(), '0);

        $display("Covered %0d words under three idle profiles: %0d results checked,",
                 words_accepted, replies_seen);
        $display("%0d commits with staged bytes and %0d image snapshots predicted.",
                 commits_seen, snapshots_seen);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### i2c_target_register_file.f
rtl/i2crf_pkg.sv
rtl/i2crf_ram.sv
rtl/i2crf_walk.sv
rtl/i2c_target_register_file.sv
rtl/i2crf_checker.sv
tb/sv/i2c_target_register_file_tb.sv
